// ===== src/subtractive_random_generator_assert.svh =====
// assertion macros for the subtractive random generator
// clk and rst are taken from the scope of the use
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SRG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srg: same-cycle check failed");

// next-cycle implication
`define SRG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srg: next-cycle check failed");

`endif

// ===== src/srg_pkg.sv =====
`timescale 1ns / 1ps

package srg_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TABLE_DEPTH = 56;
  localparam int unsigned ADDR_W      = 6;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam word_t SEED_BASE = 32'd161803398;
  localparam word_t MOD_BIG   = 32'h7FFF_FFFF;

  localparam addr_t IDX_FIRST     = 6'd1;
  localparam addr_t IDX_FILL_LAST = 6'd54;
  localparam addr_t IDX_LAST      = 6'd55;
  localparam addr_t IDX_WRAP      = 6'd56;
  localparam addr_t LEAD_START    = 6'd0;
  localparam addr_t TRAIL_START   = 6'd31;
  localparam addr_t SLOT_START    = 6'd21;
  localparam addr_t MIX_SPLIT     = 6'd25;
  localparam addr_t MIX_BACK      = 6'd24;
  localparam addr_t MIX_AHEAD     = 6'd31;
  localparam logic [6:0] SLOT_STEP = 7'd21;
  localparam logic [6:0] LAG_MOD   = 7'd55;
  localparam logic [1:0] PASS_LAST = 2'd3;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_RAW    = 2'd1,
    OP_RANGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_TAKE,
    U_SEED_INIT,
    U_FILL,
    U_MIX_INIT,
    U_MIX_READ,
    U_MIX_WRITE,
    U_PTR_RESET,
    U_ADVANCE,
    U_RAW,
    U_RANGE,
    U_MUL,
    U_DIV,
    U_DIV_FIX,
    U_SIGN,
    U_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_DISPATCH,
    BR_FILL_LOOP,
    BR_MIX_LOOP,
    BR_RANGE,
    BR_EMIT
  } br_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_t uop;
    br_t  br;
    upc_t target;
  } ctrl_t;

  localparam upc_t UA_IDLE     = 5'd0;
  localparam upc_t UA_SEED     = 5'd1;
  localparam upc_t UA_FILL     = 5'd2;
  localparam upc_t UA_MIX_INIT = 5'd3;
  localparam upc_t UA_MIX_RD   = 5'd4;
  localparam upc_t UA_MIX_WR   = 5'd5;
  localparam upc_t UA_PTR      = 5'd6;
  localparam upc_t UA_DRAW     = 5'd7;
  localparam upc_t UA_DRAW_WR  = 5'd8;
  localparam upc_t UA_RANGE    = 5'd9;
  localparam upc_t UA_RNG_RD   = 5'd10;
  localparam upc_t UA_RNG_WR   = 5'd11;
  localparam upc_t UA_MUL      = 5'd12;
  localparam upc_t UA_DIV0     = 5'd13;
  localparam upc_t UA_DIV1     = 5'd14;
  localparam upc_t UA_DIV2     = 5'd15;
  localparam upc_t UA_FIX      = 5'd16;
  localparam upc_t UA_SIGN     = 5'd17;
  localparam upc_t UA_EMIT     = 5'd18;

  // microprogram
  function automatic ctrl_t ucode(input upc_t addr);
    ctrl_t w;
    w = '{uop: U_NOP, br: BR_JUMP, target: UA_IDLE};
    unique case (addr)
      UA_IDLE:     w = '{uop: U_TAKE,      br: BR_DISPATCH,  target: UA_IDLE};
      UA_SEED:     w = '{uop: U_SEED_INIT, br: BR_NEXT,      target: UA_IDLE};
      UA_FILL:     w = '{uop: U_FILL,      br: BR_FILL_LOOP, target: UA_FILL};
      UA_MIX_INIT: w = '{uop: U_MIX_INIT,  br: BR_NEXT,      target: UA_IDLE};
      UA_MIX_RD:   w = '{uop: U_MIX_READ,  br: BR_NEXT,      target: UA_IDLE};
      UA_MIX_WR:   w = '{uop: U_MIX_WRITE, br: BR_MIX_LOOP,  target: UA_MIX_RD};
      UA_PTR:      w = '{uop: U_PTR_RESET, br: BR_JUMP,      target: UA_EMIT};
      UA_DRAW:     w = '{uop: U_ADVANCE,   br: BR_NEXT,      target: UA_IDLE};
      UA_DRAW_WR:  w = '{uop: U_RAW,       br: BR_JUMP,      target: UA_EMIT};
      UA_RANGE:    w = '{uop: U_RANGE,     br: BR_RANGE,     target: UA_EMIT};
      UA_RNG_RD:   w = '{uop: U_ADVANCE,   br: BR_NEXT,      target: UA_IDLE};
      UA_RNG_WR:   w = '{uop: U_RAW,       br: BR_NEXT,      target: UA_IDLE};
      UA_MUL:      w = '{uop: U_MUL,       br: BR_NEXT,      target: UA_IDLE};
      UA_DIV0:     w = '{uop: U_DIV,       br: BR_NEXT,      target: UA_IDLE};
      UA_DIV1:     w = '{uop: U_DIV,       br: BR_NEXT,      target: UA_IDLE};
      UA_DIV2:     w = '{uop: U_DIV,       br: BR_NEXT,      target: UA_IDLE};
      UA_FIX:      w = '{uop: U_DIV_FIX,   br: BR_NEXT,      target: UA_IDLE};
      UA_SIGN:     w = '{uop: U_SIGN,      br: BR_JUMP,      target: UA_EMIT};
      UA_EMIT:     w = '{uop: U_EMIT,      br: BR_EMIT,      target: UA_IDLE};
      default:     w = '{uop: U_NOP,       br: BR_JUMP,      target: UA_IDLE};
    endcase
    return w;
  endfunction

  // negative differences wrap back by 2^31-1
  function automatic word_t fold(input word_t x);
    return x[WORD_W-1] ? x + MOD_BIG : x;
  endfunction

endpackage

// ===== src/srg_ram.sv =====
`timescale 1ns / 1ps

module srg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 56,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/subtractive_random_generator.sv =====
`timescale 1ns / 1ps
// channel   direction  tdata                                       tuser
// s_*       in         seed[31:0] low_bound[63:32] high_bound[95:64] op[1:0]
// m_*       out        value[31:0]                                 bad_range
//
// draws advance the pointers and write the table, a ranged one then multiplies and
// divides by 2^31-1 unless the range is bad or unit; an unused op goes to emit; a
// reseed mixes each word in four passes, bound by the single-write lag table ram
// reset clears the sequencer, the pointers and the per-entry valid bits, so an
// unwritten table word reads as zero
// the emit step holds while the result register is full and not drained

module subtractive_random_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // seed, low_bound, high_bound
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value
  output logic        m_tuser    // bad_range
);

  srg_pkg::upc_t  pc;
  srg_pkg::upc_t  pc_next;
  srg_pkg::ctrl_t ctrl;

  srg_pkg::word_t seed;
  srg_pkg::word_t low_bound;
  srg_pkg::word_t high_bound;
  srg_pkg::word_t mj;
  srg_pkg::word_t mk;
  srg_pkg::addr_t idx;
  srg_pkg::addr_t slot;
  logic [1:0]     pass;
  srg_pkg::addr_t lead;
  srg_pkg::addr_t trail;
  srg_pkg::word_t result;
  logic           bad;
  srg_pkg::word_t diff;
  logic           neg;
  srg_pkg::word_t quo;
  logic [63:0]    rem;
  logic [srg_pkg::TABLE_DEPTH-1:0] filled;
  logic           rda_ok;
  logic           rdb_ok;

  logic           we;
  srg_pkg::addr_t waddr;
  srg_pkg::word_t wdata;
  srg_pkg::addr_t ra;
  srg_pkg::addr_t rb;
  srg_pkg::word_t rda;
  srg_pkg::word_t rdb;

  srg_pkg::word_t mag;
  srg_pkg::word_t mj_init;
  srg_pkg::word_t a_eff;
  srg_pkg::word_t b_eff;
  srg_pkg::word_t sub_raw;
  srg_pkg::addr_t lead_inc;
  srg_pkg::addr_t lead_adv;
  srg_pkg::addr_t trail_inc;
  srg_pkg::addr_t trail_adv;
  srg_pkg::addr_t other_idx;
  logic [6:0]     slot_sum;
  srg_pkg::addr_t slot_adv;
  logic [32:0]    diff_full;
  logic           bad_cond;
  logic           one_cond;
  srg_pkg::word_t res_mag;
  logic [63:0]    prod;
  logic [63:0]    rem_step;
  srg_pkg::word_t quo_step;
  srg_pkg::word_t ranged_val;
  logic           out_free;
  logic           mix_done;

  function automatic srg_pkg::upc_t upc_t_inc(input srg_pkg::upc_t p);
    return p + 5'd1;
  endfunction

  assign ctrl     = srg_pkg::ucode(pc);
  assign s_tready = (ctrl.br == srg_pkg::BR_DISPATCH);
  assign out_free = !m_tvalid || m_tready;

  // seed magnitude, most negative seed taken as 2^31-1
  assign mag = (seed == 32'h8000_0000) ? srg_pkg::MOD_BIG :
               (seed[31] ? (32'd0 - seed) : seed);
  assign mj_init = srg_pkg::SEED_BASE - mag;

  assign a_eff   = rda_ok ? rda : '0;
  assign b_eff   = rdb_ok ? rdb : '0;
  assign sub_raw = srg_pkg::fold(a_eff - b_eff);

  assign lead_inc  = lead + 6'd1;
  assign lead_adv  = (lead_inc >= srg_pkg::IDX_WRAP) ? srg_pkg::IDX_FIRST : lead_inc;
  assign trail_inc = trail + 6'd1;
  assign trail_adv = (trail_inc >= srg_pkg::IDX_WRAP) ? srg_pkg::IDX_FIRST : trail_inc;

  assign other_idx = (idx >= srg_pkg::MIX_SPLIT) ? (idx - srg_pkg::MIX_BACK)
                                                 : (idx + srg_pkg::MIX_AHEAD);
  assign slot_sum  = {1'b0, slot} + srg_pkg::SLOT_STEP;
  assign slot_adv  = (slot_sum >= srg_pkg::LAG_MOD) ? 6'(slot_sum - srg_pkg::LAG_MOD)
                                                    : slot_sum[5:0];
  assign mix_done  = (idx == srg_pkg::IDX_LAST) && (pass == srg_pkg::PASS_LAST);

  assign diff_full = {high_bound[31], high_bound} - {low_bound[31], low_bound};
  assign bad_cond  = $signed(high_bound) <= $signed(low_bound);
  assign one_cond  = (diff_full == 33'd1);

  assign res_mag  = result[31] ? (32'd0 - result) : result;
  assign prod     = 64'(res_mag) * 64'(diff);

  // one reduction step by 2^31-1: x = h*2^31 + l = h*M + (h + l)
  assign rem_step = {31'd0, rem[63:31]} + {33'd0, rem[30:0]};
  assign quo_step = quo + rem[62:31];

  // floor toward minus infinity for negative products
  assign ranged_val = neg ? (low_bound + ~quo + {31'd0, rem == 64'd0})
                          : (low_bound + quo);

  always_comb begin
    we    = 1'b0;
    waddr = lead;
    wdata = sub_raw;
    ra    = lead;
    rb    = trail;
    case (ctrl.uop)
      srg_pkg::U_SEED_INIT: begin
        we    = 1'b1;
        waddr = srg_pkg::IDX_LAST;
        wdata = mj_init;
      end
      srg_pkg::U_FILL: begin
        we    = 1'b1;
        waddr = slot;
        wdata = mk;
      end
      srg_pkg::U_MIX_READ: begin
        ra = idx;
        rb = other_idx;
      end
      srg_pkg::U_MIX_WRITE: begin
        we    = 1'b1;
        waddr = idx;
      end
      srg_pkg::U_ADVANCE: begin
        ra = lead_adv;
        rb = trail_adv;
      end
      srg_pkg::U_RAW: begin
        we    = 1'b1;
        waddr = lead;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    pc_next = upc_t_inc(pc);
    unique case (ctrl.br)
      srg_pkg::BR_NEXT:  pc_next = upc_t_inc(pc);
      srg_pkg::BR_JUMP:  pc_next = ctrl.target;
      srg_pkg::BR_DISPATCH: begin
        if (!s_tvalid) begin
          pc_next = pc;
        end else begin
          unique case (srg_pkg::op_t'(s_tuser))
            srg_pkg::OP_RESEED: pc_next = srg_pkg::UA_SEED;
            srg_pkg::OP_RAW:    pc_next = srg_pkg::UA_DRAW;
            srg_pkg::OP_RANGE:  pc_next = srg_pkg::UA_RANGE;
            default:            pc_next = srg_pkg::UA_EMIT;
          endcase
        end
      end
      srg_pkg::BR_FILL_LOOP: begin
        pc_next = (idx != srg_pkg::IDX_FILL_LAST) ? ctrl.target : upc_t_inc(pc);
      end
      srg_pkg::BR_MIX_LOOP: begin
        pc_next = mix_done ? upc_t_inc(pc) : ctrl.target;
      end
      srg_pkg::BR_RANGE: begin
        pc_next = (bad_cond || one_cond) ? ctrl.target : upc_t_inc(pc);
      end
      srg_pkg::BR_EMIT: begin
        pc_next = out_free ? ctrl.target : pc;
      end
      default: pc_next = srg_pkg::UA_IDLE;
    endcase
  end

  srg_ram #(
    .WIDTH(srg_pkg::WORD_W),
    .DEPTH(srg_pkg::TABLE_DEPTH),
    .AW   (srg_pkg::ADDR_W)
  ) u_lag_table (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(ra),
    .raddr_b(rb),
    .rdata_a(rda),
    .rdata_b(rdb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= srg_pkg::UA_IDLE;
      lead     <= srg_pkg::LEAD_START;
      trail    <= srg_pkg::TRAIL_START;
      filled   <= '0;
      rda_ok   <= 1'b0;
      rdb_ok   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pc     <= pc_next;
      rda_ok <= filled[ra];
      rdb_ok <= filled[rb];
      if (we) begin
        filled[waddr] <= 1'b1;
      end
      if ((ctrl.uop == srg_pkg::U_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (ctrl.uop)
        srg_pkg::U_TAKE: begin
          if (s_tvalid) begin
            seed       <= s_tdata[31:0];
            low_bound  <= s_tdata[63:32];
            high_bound <= s_tdata[95:64];
            result     <= '0;
            bad        <= 1'b0;
          end
        end
        srg_pkg::U_SEED_INIT: begin
          mj   <= mj_init;
          mk   <= 32'd1;
          idx  <= srg_pkg::IDX_FIRST;
          slot <= srg_pkg::SLOT_START;
        end
        srg_pkg::U_FILL: begin
          mk   <= srg_pkg::fold(mj - mk);
          mj   <= mk;
          idx  <= idx + 6'd1;
          slot <= slot_adv;
        end
        srg_pkg::U_MIX_INIT: begin
          idx  <= srg_pkg::IDX_FIRST;
          pass <= '0;
        end
        srg_pkg::U_MIX_WRITE: begin
          if (idx == srg_pkg::IDX_LAST) begin
            idx  <= srg_pkg::IDX_FIRST;
            pass <= pass + 2'd1;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        srg_pkg::U_PTR_RESET: begin
          lead  <= srg_pkg::LEAD_START;
          trail <= srg_pkg::TRAIL_START;
        end
        srg_pkg::U_ADVANCE: begin
          lead  <= lead_adv;
          trail <= trail_adv;
        end
        srg_pkg::U_RAW: begin
          result <= sub_raw;
        end
        srg_pkg::U_RANGE: begin
          diff <= diff_full[31:0];
          if (bad_cond) begin
            bad <= 1'b1;
          end else if (one_cond) begin
            result <= low_bound;
          end
        end
        srg_pkg::U_MUL: begin
          rem <= prod;
          quo <= '0;
          neg <= result[31];
        end
        srg_pkg::U_DIV: begin
          rem <= rem_step;
          quo <= quo_step;
        end
        srg_pkg::U_DIV_FIX: begin
          if (rem >= {32'd0, srg_pkg::MOD_BIG}) begin
            rem <= rem - {32'd0, srg_pkg::MOD_BIG};
            quo <= quo + 32'd1;
          end
        end
        srg_pkg::U_SIGN: begin
          result <= ranged_val;
        end
        srg_pkg::U_EMIT: begin
          if (out_free) begin
            m_tdata <= result;
            m_tuser <= bad;
          end
        end
        default: begin
          pass <= pass;
        end
      endcase
    end
  end

`include "subtractive_random_generator_assert.svh"

  `SRG_ASSERT_IMP(a_bad_value_zero, m_tvalid && m_tuser, m_tdata == 32'd0)
  `SRG_ASSERT_IMP(a_pointer_lag, 1'b1, (trail == lead + 6'd31) || (lead == trail + 6'd24))
  `SRG_ASSERT_NXT(a_take_leaves_idle, s_tvalid && s_tready, pc != srg_pkg::UA_IDLE)

endmodule
